// File: rtl/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Types, codes and default sizes shared by the delta-list timer queue.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int NUM_TIMERS_DEF  = 16;
    localparam int PERIOD_BITS_DEF = 24;
    localparam int MAX_OUT         = 16;

    // Fixed field widths of the stream payload.
    localparam int MODE_W   = 2;
    localparam int ID_W     = 4;
    localparam int PER_W    = 24;
    localparam int STATUS_W = 2;
    localparam int CNT_O_W  = 5;
    localparam int DL_O_W   = 24;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 40;

    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PERIOD = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ACTIVE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd3;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NOP        = 4'd0;
    localparam logic [3:0] OP_ACCEPT     = 4'd1;
    localparam logic [3:0] OP_DECIDE     = 4'd2;
    localparam logic [3:0] OP_WALK       = 4'd3;
    localparam logic [3:0] OP_MID_FIX    = 4'd4;
    localparam logic [3:0] OP_LINK       = 4'd5;
    localparam logic [3:0] OP_INS_COMMIT = 4'd6;
    localparam logic [3:0] OP_RM_READ    = 4'd7;
    localparam logic [3:0] OP_RM_NEIGH   = 4'd8;
    localparam logic [3:0] OP_RM_COMMIT  = 4'd9;
    localparam logic [3:0] OP_TICK_DEC   = 4'd10;
    localparam logic [3:0] OP_TICK_HEAD  = 4'd11;
    localparam logic [3:0] OP_OUT        = 4'd12;

    // Where a new timer lands in the list.
    localparam logic [1:0] K_EMPTY = 2'd0;
    localparam logic [1:0] K_HEAD  = 2'd1;
    localparam logic [1:0] K_TAIL  = 2'd2;
    localparam logic [1:0] K_MID   = 2'd3;

    typedef struct packed {
        logic [3:0]          op;
        logic [STATUS_W-1:0] status;
        logic                exp_valid;
        logic                last;
    } dltq_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] start_status;
        logic                ins_mid;
        logic                cancel_bad;
        logic                walk_more;
        logic                due;
        logic                drained;
        logic                out_free;
    } dltq_stat_t;

endpackage

// File: rtl/delta_list_timer_queue_top.sv
// A start result is ready sooner when it is rejected or lands at the head or tail than
// when it walks the list; a cancel is sooner when rejected; a tick gives one result with
// nothing due and else one per expiry, up to MAX_OUT. Inputs are taken one at a time; the
// next is taken the cycle after the last result of the previous one enters the output register.
// Reset (rst_n low, asynchronous) empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// delta_list_timer_queue_top
// Timer queue kept as a delta list, with start, cancel and tick commands.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_top #(
    parameter int NUM_TIMERS  = dltq_pkg::NUM_TIMERS_DEF,
    parameter int PERIOD_BITS = dltq_pkg::PERIOD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dltq_pkg::IN_W-1:0]      s_axis_tdata,  // mode, timer_id, period, zero pad
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [dltq_pkg::OUT_W-1:0]     m_axis_tdata,  // status, expired_id, active_count,
                                                          // next_deadline, zero pad
    output logic                           m_axis_tuser,  // expired_valid
    output logic                           m_axis_tlast   // last
);
    import dltq_pkg::*;

    dltq_cmd_t            cmd;
    dltq_stat_t           stat;
    logic [MODE_W-1:0]    in_mode;
    logic [ID_W-1:0]      in_id;
    logic [PER_W-1:0]     in_period;
    logic [STATUS_W-1:0]  out_status;
    logic [ID_W-1:0]      out_exp_id;
    logic [CNT_O_W-1:0]   out_count;
    logic [DL_O_W-1:0]    out_deadline;

    assign in_mode   = s_axis_tdata[MODE_W-1:0];
    assign in_id     = s_axis_tdata[MODE_W+ID_W-1:MODE_W];
    assign in_period = s_axis_tdata[MODE_W+ID_W+PER_W-1:MODE_W+ID_W];

    assign m_axis_tdata = {5'd0, out_deadline, out_count, out_exp_id, out_status};

    dltq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (in_mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    dltq_dp #(
        .NUM_TIMERS  (NUM_TIMERS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_id         (in_id),
        .in_period     (in_period),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_status    (out_status),
        .out_exp_valid (m_axis_tuser),
        .out_exp_id    (out_exp_id),
        .out_last      (m_axis_tlast),
        .out_count     (out_count),
        .out_deadline  (out_deadline)
    );

endmodule

// File: rtl/dltq_dp.sv
// ----------------------------------------------------------------------------
// dltq_dp
// Datapath: link and gap memories, queue registers and the result register.
// ----------------------------------------------------------------------------
module dltq_dp #(
    parameter int NUM_TIMERS  = dltq_pkg::NUM_TIMERS_DEF,
    parameter int PERIOD_BITS = dltq_pkg::PERIOD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dltq_pkg::dltq_cmd_t           cmd,
    output dltq_pkg::dltq_stat_t          stat,
    input  logic [dltq_pkg::ID_W-1:0]     in_id,
    input  logic [dltq_pkg::PER_W-1:0]    in_period,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dltq_pkg::STATUS_W-1:0] out_status,
    output logic                          out_exp_valid,
    output logic [dltq_pkg::ID_W-1:0]     out_exp_id,
    output logic                          out_last,
    output logic [dltq_pkg::CNT_O_W-1:0]  out_count,
    output logic [dltq_pkg::DL_O_W-1:0]   out_deadline
);
    import dltq_pkg::*;

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int LW = IW + 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int PW = PERIOD_BITS;
    localparam logic [LW-1:0] NIL = {LW{1'b1}};
    localparam logic [32:0] PMAX = (33'd1 << PERIOD_BITS) - 33'd1;

    logic [LW-1:0] nxt_mem [NUM_TIMERS];
    logic [LW-1:0] prv_mem [NUM_TIMERS];
    logic [PW-1:0] gap_mem [NUM_TIMERS];
    logic [LW-1:0] nxt_q, prv_q;
    logic [PW-1:0] gap_q;

    logic [ID_W-1:0]  id_reg;
    logic [PER_W-1:0] per_reg;
    logic [LW-1:0]    t_reg, n_reg, pv_reg, nx_reg;
    logic [PW-1:0]    sum_reg, gt_reg, gpv_reg, sh_reg;
    logic [1:0]       kind_reg;

    logic [LW-1:0]         head_reg, tail_reg;
    logic [PW-1:0]         hr_reg, span_reg;
    logic [CW-1:0]         cnt_reg;
    logic [NUM_TIMERS-1:0] inq_reg;

    logic [PW-1:0] p_w;
    logic          id_bad, too_big;
    logic [1:0]    ins_kind;
    logic [LW-1:0] rd_addr;

    logic          nxt_we, prv_we, gap_we;
    logic [LW-1:0] nxt_wa, prv_wa, gap_wa;
    logic [LW-1:0] nxt_wd, prv_wd;
    logic [PW-1:0] gap_wd;

    assign p_w     = PW'(per_reg);
    assign too_big = (33'(per_reg) > PMAX);
    assign id_bad  = (32'(id_reg) >= NUM_TIMERS);

    always_comb
    begin
        if (cnt_reg == '0)
            ins_kind = K_EMPTY;
        else if (hr_reg > p_w)
            ins_kind = K_HEAD;
        else if (sh_reg <= p_w)
            ins_kind = K_TAIL;
        else
            ins_kind = K_MID;
    end

    always_comb
    begin
        if (per_reg == '0 || too_big)
            stat.start_status = ST_BAD_PERIOD;
        else if (id_bad)
            stat.start_status = ST_NOT_ACTIVE;
        else if (inq_reg[t_reg[IW-1:0]])
            stat.start_status = ST_ACTIVE;
        else
            stat.start_status = ST_OK;
        stat.ins_mid    = (ins_kind == K_MID);
        stat.cancel_bad = id_bad || !inq_reg[t_reg[IW-1:0]];
        stat.walk_more  = (sum_reg <= p_w);
        stat.due        = (cnt_reg != '0) && (hr_reg == '0);
        stat.drained    = (cnt_reg == '0) || (hr_reg != '0);
        stat.out_free   = !out_valid || out_ready;
    end

    always_comb
    begin
        case (cmd.op)
            OP_DECIDE:    rd_addr = head_reg;
            OP_WALK:      rd_addr = nxt_q;
            OP_TICK_HEAD: rd_addr = head_reg;
            OP_RM_NEIGH:  rd_addr = prv_q;
            default:      rd_addr = t_reg;
        endcase
    end

    // Write ports: each memory takes at most one write per operation.
    always_comb
    begin
        nxt_we = 1'b0;
        prv_we = 1'b0;
        gap_we = 1'b0;
        nxt_wa = t_reg;
        prv_wa = t_reg;
        gap_wa = t_reg;
        nxt_wd = n_reg;
        prv_wd = pv_reg;
        gap_wd = gt_reg;
        case (cmd.op)
            OP_LINK:
            begin
                prv_we = (n_reg != NIL);
                prv_wa = n_reg;
                prv_wd = t_reg;
                nxt_we = (pv_reg != NIL);
                nxt_wa = pv_reg;
                nxt_wd = t_reg;
                gap_we = (pv_reg != NIL);
                gap_wa = pv_reg;
                gap_wd = gpv_reg;
            end
            OP_INS_COMMIT:
            begin
                nxt_we = 1'b1;
                prv_we = 1'b1;
                gap_we = 1'b1;
            end
            OP_RM_COMMIT:
            begin
                nxt_we = (pv_reg != NIL);
                nxt_wa = pv_reg;
                nxt_wd = nx_reg;
                prv_we = (nx_reg != NIL);
                prv_wa = nx_reg;
                prv_wd = pv_reg;
                gap_wa = pv_reg;
                if (head_reg != t_reg && tail_reg == t_reg)
                begin
                    gap_we = 1'b1;
                    gap_wd = '0;
                end
                else if (head_reg != t_reg)
                begin
                    gap_we = 1'b1;
                    gap_wd = gap_q + gt_reg;
                end
            end
            default:
            begin
                nxt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
            nxt_mem[nxt_wa[IW-1:0]] <= nxt_wd;
        if (prv_we)
            prv_mem[prv_wa[IW-1:0]] <= prv_wd;
        if (gap_we)
            gap_mem[gap_wa[IW-1:0]] <= gap_wd;
        nxt_q <= nxt_mem[rd_addr[IW-1:0]];
        prv_q <= prv_mem[rd_addr[IW-1:0]];
        gap_q <= gap_mem[rd_addr[IW-1:0]];
    end

    // Scratch registers of the current operation.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                id_reg  <= in_id;
                per_reg <= in_period;
                t_reg   <= LW'(in_id);
                sh_reg  <= span_reg + hr_reg;
            end
            OP_DECIDE:
            begin
                kind_reg <= ins_kind;
                sum_reg  <= hr_reg;
                case (ins_kind)
                    K_EMPTY:
                    begin
                        n_reg  <= NIL;
                        pv_reg <= NIL;
                        gt_reg <= '0;
                    end
                    K_HEAD:
                    begin
                        n_reg  <= head_reg;
                        pv_reg <= NIL;
                        gt_reg <= hr_reg - p_w;
                    end
                    K_TAIL:
                    begin
                        n_reg   <= NIL;
                        pv_reg  <= tail_reg;
                        gt_reg  <= '0;
                        gpv_reg <= p_w - sh_reg;
                    end
                    default:
                    begin
                        n_reg  <= head_reg;
                        pv_reg <= NIL;
                    end
                endcase
            end
            OP_WALK:
            begin
                if (sum_reg <= p_w)
                begin
                    pv_reg  <= n_reg;
                    gpv_reg <= gap_q;
                    sum_reg <= sum_reg + gap_q;
                    n_reg   <= nxt_q;
                end
                else
                    gt_reg <= sum_reg - p_w;
            end
            OP_MID_FIX:
                gpv_reg <= gpv_reg - gt_reg;
            OP_TICK_HEAD:
                t_reg <= head_reg;
            OP_RM_NEIGH:
            begin
                pv_reg <= prv_q;
                nx_reg <= nxt_q;
                gt_reg <= gap_q;
            end
            default:
            begin
                kind_reg <= kind_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NIL;
            tail_reg <= NIL;
            hr_reg   <= '0;
            span_reg <= '0;
            cnt_reg  <= '0;
            inq_reg  <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_INS_COMMIT:
                begin
                    inq_reg[t_reg[IW-1:0]] <= 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                    case (kind_reg)
                        K_EMPTY:
                        begin
                            head_reg <= t_reg;
                            tail_reg <= t_reg;
                            hr_reg   <= p_w;
                            span_reg <= '0;
                        end
                        K_HEAD:
                        begin
                            head_reg <= t_reg;
                            span_reg <= span_reg + gt_reg;
                            hr_reg   <= p_w;
                        end
                        K_TAIL:
                        begin
                            tail_reg <= t_reg;
                            span_reg <= p_w - hr_reg;
                        end
                        default:
                        begin
                            span_reg <= span_reg;
                        end
                    endcase
                end
                OP_RM_COMMIT:
                begin
                    if (head_reg == t_reg && tail_reg == t_reg)
                    begin
                        hr_reg   <= '0;
                        span_reg <= '0;
                    end
                    else if (head_reg == t_reg)
                    begin
                        hr_reg   <= hr_reg + gt_reg;
                        span_reg <= span_reg - gt_reg;
                    end
                    else if (tail_reg == t_reg)
                        span_reg <= span_reg - gap_q;
                    if (pv_reg == NIL)
                        head_reg <= nx_reg;
                    if (nx_reg == NIL)
                        tail_reg <= pv_reg;
                    inq_reg[t_reg[IW-1:0]] <= 1'b0;
                    if (cnt_reg != '0)
                        cnt_reg <= cnt_reg - 1'b1;
                end
                OP_TICK_DEC:
                begin
                    if (cnt_reg != '0 && hr_reg != '0)
                        hr_reg <= hr_reg - 1'b1;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.op == OP_OUT)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            out_status    <= cmd.status;
            out_exp_valid <= cmd.exp_valid;
            out_exp_id    <= cmd.exp_valid ? ID_W'(t_reg) : '0;
            out_last      <= cmd.last;
            out_count     <= CNT_O_W'(cnt_reg);
            out_deadline  <= DL_O_W'(hr_reg);
        end
    end

endmodule

// File: rtl/dltq_ctrl.sv
// ----------------------------------------------------------------------------
// dltq_ctrl
// Controller: sequences start, cancel and tick over the datapath.
// ----------------------------------------------------------------------------
module dltq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dltq_pkg::MODE_W-1:0] in_mode,
    input  dltq_pkg::dltq_stat_t        stat,
    output dltq_pkg::dltq_cmd_t         cmd
);
    import dltq_pkg::*;

    localparam int KW = $clog2(MAX_OUT);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ST_CHK = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_MFIX   = 4'd3;
    localparam logic [3:0] S_LINK   = 4'd4;
    localparam logic [3:0] S_INS_C  = 4'd5;
    localparam logic [3:0] S_CN_CHK = 4'd6;
    localparam logic [3:0] S_RM_N   = 4'd7;
    localparam logic [3:0] S_RM_C   = 4'd8;
    localparam logic [3:0] S_TK_DEC = 4'd9;
    localparam logic [3:0] S_TK_CHK = 4'd10;
    localparam logic [3:0] S_TK_OUT = 4'd11;
    localparam logic [3:0] S_RESP   = 4'd12;

    logic [3:0]          state_reg, state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [KW-1:0]       k_reg, k_next;
    logic                tick_reg, tick_next;
    logic                tk_last;

    assign tk_last = stat.drained || (k_reg == KW'(MAX_OUT - 1));

    always_comb
    begin
        state_next    = state_reg;
        status_next   = status_reg;
        k_next        = k_reg;
        tick_next     = tick_reg;
        in_ready      = 1'b0;
        cmd.op        = OP_NOP;
        cmd.status    = status_reg;
        cmd.exp_valid = 1'b0;
        cmd.last      = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op    = OP_ACCEPT;
                    tick_next = (in_mode == MODE_TICK);
                    case (in_mode)
                        MODE_START:  state_next = S_ST_CHK;
                        MODE_CANCEL: state_next = S_CN_CHK;
                        MODE_TICK:   state_next = S_TK_DEC;
                        default:
                        begin
                            status_next = ST_OK;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end
            S_ST_CHK:
            begin
                if (stat.start_status != ST_OK)
                begin
                    status_next = stat.start_status;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.op     = OP_DECIDE;
                    state_next = stat.ins_mid ? S_WALK : S_LINK;
                end
            end
            S_WALK:
            begin
                cmd.op = OP_WALK;
                if (!stat.walk_more)
                    state_next = S_MFIX;
            end
            S_MFIX:
            begin
                cmd.op     = OP_MID_FIX;
                state_next = S_LINK;
            end
            S_LINK:
            begin
                cmd.op     = OP_LINK;
                state_next = S_INS_C;
            end
            S_INS_C:
            begin
                cmd.op      = OP_INS_COMMIT;
                status_next = ST_OK;
                state_next  = S_RESP;
            end
            S_CN_CHK:
            begin
                if (stat.cancel_bad)
                begin
                    status_next = ST_NOT_ACTIVE;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.op     = OP_RM_READ;
                    state_next = S_RM_N;
                end
            end
            S_RM_N:
            begin
                cmd.op     = OP_RM_NEIGH;
                state_next = S_RM_C;
            end
            S_RM_C:
            begin
                cmd.op      = OP_RM_COMMIT;
                status_next = ST_OK;
                state_next  = tick_reg ? S_TK_OUT : S_RESP;
            end
            S_TK_DEC:
            begin
                cmd.op     = OP_TICK_DEC;
                k_next     = '0;
                state_next = S_TK_CHK;
            end
            S_TK_CHK:
            begin
                if (stat.due)
                begin
                    cmd.op     = OP_TICK_HEAD;
                    state_next = S_RM_N;
                end
                else
                begin
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
            end
            S_TK_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op        = OP_OUT;
                    cmd.status    = ST_OK;
                    cmd.exp_valid = 1'b1;
                    cmd.last      = tk_last;
                    k_next        = k_reg + 1'b1;
                    state_next    = tk_last ? S_IDLE : S_TK_CHK;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
            k_reg      <= '0;
            tick_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            k_reg      <= k_next;
            tick_reg   <= tick_next;
        end
    end

endmodule

// File: rtl/dltq_checker.sv
// ----------------------------------------------------------------------------
// dltq_checker
// Port-level assertions for the delta-list timer queue.
// ----------------------------------------------------------------------------
module dltq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [dltq_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic                       m_axis_tuser,
    input logic                       m_axis_tlast
);
    import dltq_pkg::*;

    // A result that does not report an expiry closes its input transfer.
    a_plain_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("non-expiry result without last");

    a_plain_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[5:2] == '0)
        else $error("expired_id set on a non-expiry result");

    a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == ST_OK)
        else $error("expiry result with non-zero status");

    // Items are handled one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

endmodule

bind delta_list_timer_queue_top dltq_checker u_dltq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: test/tb_delta_list_timer_queue_top.sv
// ----------------------------------------------------------------------------
// Testbench for the delta-list timer queue
// Drives start, cancel and tick commands over the input stream, predicts every
// result from a software copy of the deadline list, and checks each output
// transfer field by field, with random gaps on both sides of the block.
// ----------------------------------------------------------------------------
module tb_delta_list_timer_queue_top;

    import dltq_pkg::*;

    localparam int NT    = 16;
    localparam int NIL   = 255;
    localparam int PMAX  = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic        exp_valid;
        logic [3:0]  exp_id;
        logic        last;
        logic [4:0]  count;
        logic [23:0] deadline;
    } timer_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    delta_list_timer_queue_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Software copy of the deadline list.
    int          nxt [NT];
    int          prv [NT];
    longint      gap [NT];
    bit          queued [NT];
    int          head_id;
    int          tail_id;
    longint      head_left;
    longint      span;
    int          n_active;

    timer_result_t expected_results[$];
    int            n_errors;
    int            n_items;
    int            n_expiries;
    bit            sink_busy_mode;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("%0t timeout", $time);
        $display("tb_delta_list_timer_queue_top: errors");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(3, 30);
    endfunction

    function automatic void push_result(logic [1:0] st, logic v, int id, logic lst);
        timer_result_t r;
        r.status    = st;
        r.exp_valid = v;
        r.exp_id    = id[3:0];
        r.last      = lst;
        r.count     = n_active[4:0];
        r.deadline  = head_left[23:0];
        expected_results.push_back(r);
    endfunction

    function automatic void link_timer(int t, longint p);
        longint acc;
        int     n;
        int     pv;
        int     guard;
        queued[t] = 1'b1;
        if (n_active == 0) begin
            head_left = p;
            span      = 0;
            gap[t]    = 0;
            nxt[t]    = NIL;
            prv[t]    = NIL;
            head_id   = t;
            tail_id   = t;
        end else if (head_left > p) begin
            gap[t]       = head_left - p;
            span        += gap[t];
            head_left    = p;
            nxt[t]       = head_id;
            prv[t]       = NIL;
            prv[head_id] = t;
            head_id      = t;
        end else if (span + head_left <= p) begin
            gap[tail_id] = p - (span + head_left);
            span         = p - head_left;
            gap[t]       = 0;
            nxt[t]       = NIL;
            prv[t]       = tail_id;
            nxt[tail_id] = t;
            tail_id      = t;
        end else begin
            acc   = head_left;
            n     = head_id;
            guard = 0;
            while (acc <= p && nxt[n] != NIL && guard < NT) begin
                acc += gap[n];
                n    = nxt[n];
                guard++;
            end
            pv     = prv[n];
            gap[t] = acc - p;
            if (pv != NIL)
                gap[pv] -= gap[t];
            nxt[t] = n;
            prv[t] = pv;
            prv[n] = t;
            if (pv != NIL)
                nxt[pv] = t;
            else
                head_id = t;
        end
        n_active++;
    endfunction

    function automatic void unlink_timer(int t);
        int pv;
        int nx;
        pv = prv[t];
        nx = nxt[t];
        if (head_id == t && tail_id == t) begin
            head_left = 0;
            span      = 0;
        end else if (head_id == t) begin
            head_left += gap[t];
            span      -= gap[t];
        end else if (tail_id == t) begin
            span   -= gap[pv];
            gap[pv] = 0;
        end else begin
            gap[pv] += gap[t];
        end
        if (pv != NIL) nxt[pv] = nx; else head_id = nx;
        if (nx != NIL) prv[nx] = pv; else tail_id = pv;
        nxt[t]    = NIL;
        prv[t]    = NIL;
        queued[t] = 1'b0;
        if (n_active > 0) n_active--;
    endfunction

    // Works out every result that one command causes.
    function automatic void predict_command(logic [1:0] mode, int id, longint p);
        logic [1:0] st;
        int         k;
        int         h;
        st = ST_OK;
        if (mode == MODE_START) begin
            if (p == 0 || p > PMAX) st = ST_BAD_PERIOD;
            else if (queued[id]) st = ST_ACTIVE;
            else link_timer(id, p);
            push_result(st, 1'b0, 0, 1'b1);
        end else if (mode == MODE_CANCEL) begin
            if (!queued[id]) st = ST_NOT_ACTIVE;
            else unlink_timer(id);
            push_result(st, 1'b0, 0, 1'b1);
        end else if (mode == MODE_TICK) begin
            k = 0;
            if (n_active > 0 && head_left > 0)
                head_left--;
            while (k < MAX_OUT && n_active > 0 && head_left == 0) begin
                h = head_id;
                unlink_timer(h);
                push_result(ST_OK, 1'b1, h, 1'b0);
                k++;
                n_expiries++;
            end
            if (k == 0)
                push_result(ST_OK, 1'b0, 0, 1'b1);
            else
                expected_results[$].last = 1'b1;
        end else begin
            push_result(ST_OK, 1'b0, 0, 1'b1);
        end
    endfunction

    // The first wait always moves past the edge at which the previous transfer ended.
    task automatic send_command(logic [1:0] mode, int id, longint p);
        int g;
        g = gap_len();
        repeat (g + 1) @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, p[23:0], id[3:0], mode};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predict_command(mode, id, p);
        n_items++;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= $urandom;
    endtask

    // Sink side: random back-pressure, checking each output transfer.
    initial
    begin
        timer_result_t want;
        timer_result_t got;
        int            hold;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.status    = m_axis_tdata[1:0];
                got.exp_id    = m_axis_tdata[5:2];
                got.count     = m_axis_tdata[10:6];
                got.deadline  = m_axis_tdata[34:11];
                got.exp_valid = m_axis_tuser;
                got.last      = m_axis_tlast;
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: actual %p", $time, got);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t mismatch: expected %p actual %p", $time, want, got);
                        n_errors++;
                    end
                end
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (sink_busy_mode && $urandom_range(0, 3) == 0) begin
                hold = gap_len();
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic drain();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic longint rand_period();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(1, 3);
            1:       return $urandom_range(1, 12);
            2:       return $urandom_range(1, 40);
            3:       return PMAX - $urandom_range(0, 3);
            4:       return $urandom & PMAX;
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic test_status_codes();
        send_command(MODE_START, 0, 0);
        send_command(MODE_CANCEL, 5, 1);
        send_command(MODE_TICK, 0, 0);
        send_command(2'd3, 15, PMAX);
        send_command(MODE_START, 15, PMAX);
        send_command(MODE_START, 15, 7);
        send_command(MODE_START, 15, 0);
        send_command(MODE_CANCEL, 15, 0);
        send_command(MODE_TICK, 9, 3);
        drain();
    endtask

    task automatic test_ordering_and_ties();
        send_command(MODE_START, 1, 5);
        send_command(MODE_START, 2, 3);
        send_command(MODE_START, 3, 9);
        send_command(MODE_START, 4, 5);
        send_command(MODE_START, 5, 4);
        send_command(MODE_START, 6, 9);
        send_command(MODE_CANCEL, 5, 0);
        send_command(MODE_CANCEL, 6, 0);
        send_command(MODE_CANCEL, 2, 0);
        repeat (10) send_command(MODE_TICK, 0, 0);
        drain();
    endtask

    task automatic test_mass_expiry();
        for (int i = 0; i < NT; i++)
            send_command(MODE_START, i, 1);
        send_command(MODE_TICK, 0, 0);
        for (int i = 0; i < NT; i++)
            send_command(MODE_START, i, 2);
        send_command(MODE_TICK, 0, 0);
        send_command(MODE_TICK, 0, 0);
        drain();
    endtask

    task automatic test_random_traffic(int count);
        int     sel;
        int     id;
        longint p;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 19);
            id  = $urandom_range(0, NT - 1);
            if (sel < 8) begin
                p = ($urandom_range(0, 19) == 0) ? 0 : rand_period();
                send_command(MODE_START, id, p);
            end else if (sel < 11) begin
                send_command(MODE_CANCEL, id, $urandom & PMAX);
            end else if (sel < 19) begin
                send_command(MODE_TICK, id, $urandom & PMAX);
            end else begin
                send_command(2'd3, id, $urandom & PMAX);
            end
            if (i % 60 == 59)
                sink_busy_mode = ~sink_busy_mode;
        end
        drain();
    endtask

    initial
    begin
        n_errors       = 0;
        n_items        = 0;
        n_expiries     = 0;
        sink_busy_mode = 1'b1;
        for (int i = 0; i < NT; i++) begin
            nxt[i]    = NIL;
            prv[i]    = NIL;
            gap[i]    = 0;
            queued[i] = 1'b0;
        end
        head_id       = NIL;
        tail_id       = NIL;
        head_left     = 0;
        span          = 0;
        n_active      = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_status_codes();
        test_ordering_and_ties();
        test_mass_expiry();
        test_random_traffic(310);

        $display("Covered %0d commands with %0d timer expiries, including status codes,",
                 n_items, n_expiries);
        $display("tied deadlines, cancels anywhere in the list and full expiry bursts.");
        if (n_errors == 0)
            $display("tb_delta_list_timer_queue_top: clean");
        else
            $display("tb_delta_list_timer_queue_top: errors");
        $finish;
    end

endmodule
